@@ src/animated_image_container_validator_assert.svh @@
// Assertion macros used by the validator back end.
`ifndef ANIMATED_IMAGE_CONTAINER_VALIDATOR_ASSERT_SVH
`define ANIMATED_IMAGE_CONTAINER_VALIDATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define AICV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define AICV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AICV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define AICV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/aicv_pkg.sv @@
// ----------------------------------------------------------------------------
// aicv_pkg
// Types, codes and helper functions of the animated image container validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aicv_pkg;

    localparam int LEN_BITS_DEFAULT = 32;

    localparam logic [15:0] YEAR_MIN_RESET = 16'd1987;
    localparam logic [15:0] YEAR_MAX_RESET = 16'd2020;

    localparam logic CFG_YEAR_MIN = 1'b0;
    localparam logic CFG_YEAR_MAX = 1'b1;

    localparam logic [31:0] MAGIC_CAFF = 32'h4646_4143;
    localparam logic [31:0] MAGIC_CIFF = 32'h4646_4943;
    localparam int FIXED_IMG_HDR = 36;
    localparam int HDR_BLOCK_LEN = 20;
    localparam int CREDITS_FIXED = 14;
    localparam int DURATION_LEN  = 8;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_CREDITS = 2'd2;
    localparam logic [1:0] KIND_ANIM    = 2'd3;

    localparam logic [4:0] ERR_NONE      = 5'd0;
    localparam logic [4:0] ERR_HDR_ID    = 5'd1;
    localparam logic [4:0] ERR_HDR_MAGIC = 5'd2;
    localparam logic [4:0] ERR_HDR_LEN   = 5'd3;
    localparam logic [4:0] ERR_HDR_SIZE  = 5'd4;
    localparam logic [4:0] ERR_BLOCK_ID  = 5'd5;
    localparam logic [4:0] ERR_CREDITS2  = 5'd6;
    localparam logic [4:0] ERR_DATE      = 5'd7;
    localparam logic [4:0] ERR_BLOCK_LEN = 5'd8;
    localparam logic [4:0] ERR_IMG_MAGIC = 5'd9;
    localparam logic [4:0] ERR_IMG_SIZE  = 5'd10;
    localparam logic [4:0] ERR_CAPTION   = 5'd11;
    localparam logic [4:0] ERR_TAGS      = 5'd12;
    localparam logic [4:0] ERR_NO_CRED   = 5'd13;
    localparam logic [4:0] ERR_TRAILING  = 5'd14;
    localparam logic [4:0] ERR_EARLY_END = 5'd15;
    localparam logic [4:0] ERR_FIELD_BIG = 5'd16;

    typedef enum logic [4:0] {
        PH_HID, PH_HLEN, PH_HMAGIC, PH_HSIZE, PH_HNUM,
        PH_BID, PH_BLEN, PH_DATE, PH_CLEN, PH_CREATOR,
        PH_DUR, PH_CMAGIC, PH_CHS, PH_CCS, PH_CW, PH_CH,
        PH_CAPTION, PH_TAGS, PH_PIX, PH_DONE, PH_ENDED
    } t_phase;

    // One byte beat with the flags the front end derives from it.
    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       id_ok;
        logic       is_newline;
        logic       is_zero;
    } t_beat;

    typedef struct packed {
        logic [4:0] error_code;
        logic       finished_ok;
        logic       pixel_valid;
        logic [7:0] pixel_first;
        logic [7:0] pixel_second;
        logic [7:0] pixel_third;
        logic [1:0] block_kind;
    } t_result;

    // Number of bytes a phase assembles into one field, zero if none.
    function automatic logic [3:0] field_bytes(input t_phase ph);
        logic [3:0] n;
        case (ph)
            PH_HMAGIC, PH_CMAGIC: n = 4'd4;
            PH_DATE:              n = 4'd6;
            PH_HLEN, PH_HSIZE, PH_HNUM, PH_BLEN, PH_CLEN, PH_DUR,
            PH_CHS, PH_CCS, PH_CW, PH_CH: n = 4'd8;
            default:              n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic date_ok(input logic [47:0] d, input logic [15:0] ymin,
                                     input logic [15:0] ymax);
        logic [15:0] yr;
        logic [7:0]  mo;
        logic [7:0]  dy;
        logic [7:0]  hr;
        logic [7:0]  mi;
        logic [7:0]  md;
        yr = d[15:0];
        mo = d[23:16];
        dy = d[31:24];
        hr = d[39:32];
        mi = d[47:40];
        md = 8'd31;
        if (mo == 8'd4 || mo == 8'd6 || mo == 8'd9 || mo == 8'd11) begin
            md = 8'd30;
        end else if (mo == 8'd2) begin
            md = (yr[1:0] == 2'b00) ? 8'd29 : 8'd28;
        end
        return (yr >= ymin) && (yr <= ymax) && (mo != 8'd0) && (mo <= 8'd12) &&
               (dy <= md) && (hr <= 8'd24) && (mi < 8'd60);
    endfunction

endpackage
`default_nettype wire

@@ src/aicv_front.sv @@
// ----------------------------------------------------------------------------
// aicv_front
// Accepts byte beats, tags them with byte classes and queues two of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aicv_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_end_of_file,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output aicv_pkg::t_beat       o_beat
);
    import aicv_pkg::*;

    t_beat      r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_beat      w_beat;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_beat  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        w_beat.data       = i_data_byte;
        w_beat.eof        = i_end_of_file;
        w_beat.id_ok      = (i_data_byte >= 8'd1) && (i_data_byte <= 8'd3);
        w_beat.is_newline = (i_data_byte == 8'h0A);
        w_beat.is_zero    = (i_data_byte == 8'h00);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

@@ src/aicv_back.sv @@
// ----------------------------------------------------------------------------
// aicv_back
// Parses queued beats against the container layout and registers one result
// per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "animated_image_container_validator_assert.svh"
module aicv_back #(
    parameter int LEN_BITS = aicv_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [15:0]      i_year_min,
    input  wire logic [15:0]      i_year_max,
    input  wire logic             i_q_valid,
    output logic                  o_q_ready,
    input  aicv_pkg::t_beat       i_beat,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output aicv_pkg::t_result     o_result
);
    import aicv_pkg::*;

    localparam int W    = LEN_BITS;
    localparam int AccW = 2 * LEN_BITS + 2;

    t_phase          r_phase, n_phase;
    logic [3:0]      r_cnt, n_cnt;
    logic [63:0]     r_asm, n_asm;
    logic [W-1:0]    r_region, n_region;
    logic [W-1:0]    r_blen, n_blen;
    logic [W-1:0]    r_hsize, n_hsize;
    logic [W-1:0]    r_csize, n_csize;
    logic [W+1:0]    r_w3, n_w3;
    logic [AccW-1:0] r_acc, n_acc;
    logic [W-1:0]    r_fcount, n_fcount;
    logic [W:0]      r_frames, n_frames;
    logic [W:0]      r_blocks, n_blocks;
    logic            r_credits, n_credits;
    logic [15:0]     r_hold, n_hold;
    logic [4:0]      r_err, n_err;
    logic [1:0]      r_id, n_id;
    logic            r_out_valid;
    t_result         r_out, n_out;

    logic            w_take;
    logic [63:0]     w_asm_or;
    logic [3:0]      w_cnt_inc;
    logic [3:0]      w_lim;
    logic            w_done;
    logic [W-1:0]    w_v;
    logic            w_over;
    logic [W-1:0]    w_reg_inc;
    logic [W+9:0]    w_prod;
    logic [AccW-1:0] w_acc_n;
    logic            w_end_cred;
    logic            w_end_anim;
    logic            w_loop;
    logic [1:0]      w_kind;
    logic            w_pv;
    logic [7:0]      w_p1, w_p2, w_p3;

    assign w_take    = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_ready = w_take;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    assign w_asm_or  = r_asm | ({56'd0, i_beat.data} << {r_cnt[2:0], 3'b000});
    assign w_cnt_inc = r_cnt + 4'd1;
    assign w_lim     = field_bytes(r_phase);
    assign w_done    = (w_cnt_inc >= w_lim);
    assign w_v       = w_asm_or[W-1:0];
    assign w_over    = |(w_asm_or >> W);
    assign w_reg_inc = r_region + W'(1);
    // Height bytes are folded into 3*width*height one byte at a time.
    assign w_prod    = r_w3 * i_beat.data;
    assign w_acc_n   = r_acc + (AccW'(w_prod) << {r_cnt[2:0], 3'b000});

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_asm     = r_asm;
        n_region  = r_region;
        n_blen    = r_blen;
        n_hsize   = r_hsize;
        n_csize   = r_csize;
        n_w3      = r_w3;
        n_acc     = r_acc;
        n_fcount  = r_fcount;
        n_frames  = r_frames;
        n_blocks  = r_blocks;
        n_credits = r_credits;
        n_hold    = r_hold;
        n_err     = r_err;
        n_id      = r_id;
        w_end_cred = 1'b0;
        w_end_anim = 1'b0;
        w_loop     = 1'b0;
        w_kind     = KIND_NONE;
        w_pv       = 1'b0;
        w_p1       = 8'd0;
        w_p2       = 8'd0;
        w_p3       = 8'd0;

        if (w_take && r_err == ERR_NONE) begin
            if (w_lim != 4'd0) begin
                n_asm = w_done ? 64'd0 : w_asm_or;
                n_cnt = w_done ? 4'd0 : w_cnt_inc;
            end
            case (r_phase)
                PH_HID: begin
                    w_kind = KIND_HEADER;
                    if (i_beat.data != 8'd1) n_err = ERR_HDR_ID;
                    else n_phase = PH_HLEN;
                end
                PH_HLEN: begin
                    w_kind = KIND_HEADER;
                    if (w_done) begin
                        n_blen  = w_v;
                        n_phase = PH_HMAGIC;
                        if (w_over) n_err = ERR_FIELD_BIG;
                    end
                end
                PH_HMAGIC: begin
                    w_kind = KIND_HEADER;
                    if (w_done) begin
                        if (w_asm_or[31:0] != MAGIC_CAFF) n_err = ERR_HDR_MAGIC;
                        else n_phase = PH_HSIZE;
                    end
                end
                PH_HSIZE: begin
                    w_kind = KIND_HEADER;
                    if (w_done) begin
                        n_hsize = w_v;
                        n_phase = PH_HNUM;
                        if (w_over) n_err = ERR_FIELD_BIG;
                    end
                end
                PH_HNUM: begin
                    w_kind = KIND_HEADER;
                    if (w_done) begin
                        if (w_over) begin
                            n_err = ERR_FIELD_BIG;
                        end else begin
                            n_fcount = w_v;
                            if (r_blen != W'(HDR_BLOCK_LEN)) n_err = ERR_HDR_LEN;
                            else if (r_hsize != W'(HDR_BLOCK_LEN)) n_err = ERR_HDR_SIZE;
                            else w_loop = 1'b1;
                        end
                    end
                end
                PH_BID: begin
                    if (!i_beat.id_ok) begin
                        n_err = ERR_BLOCK_ID;
                    end else if (i_beat.data[1:0] == KIND_CREDITS && r_credits) begin
                        n_err = ERR_CREDITS2;
                    end else begin
                        n_id    = i_beat.data[1:0];
                        w_kind  = i_beat.data[1:0];
                        n_phase = PH_BLEN;
                    end
                end
                PH_BLEN: begin
                    w_kind = r_id;
                    if (w_done) begin
                        n_blen = w_v;
                        if (w_over) begin
                            n_err = ERR_FIELD_BIG;
                        end else if (r_id == KIND_HEADER) begin
                            // An extra header-id block carries nothing.
                            if (w_v != W'(0)) begin
                                n_err = ERR_BLOCK_LEN;
                            end else begin
                                n_blocks = r_blocks + (W+1)'(1);
                                w_loop   = 1'b1;
                            end
                        end else if (r_id == KIND_CREDITS) begin
                            n_phase = PH_DATE;
                        end else begin
                            n_phase = PH_DUR;
                        end
                    end
                end
                PH_DATE: begin
                    w_kind = KIND_CREDITS;
                    if (w_done) begin
                        if (!date_ok(w_asm_or[47:0], i_year_min, i_year_max)) n_err = ERR_DATE;
                        else n_phase = PH_CLEN;
                    end
                end
                PH_CLEN: begin
                    w_kind = KIND_CREDITS;
                    if (w_done) begin
                        if (w_over) begin
                            n_err = ERR_FIELD_BIG;
                        end else begin
                            n_csize  = w_v;
                            n_region = W'(0);
                            if (w_v == W'(0)) w_end_cred = 1'b1;
                            else n_phase = PH_CREATOR;
                        end
                    end
                end
                PH_CREATOR: begin
                    w_kind   = KIND_CREDITS;
                    n_region = w_reg_inc;
                    if (w_reg_inc >= r_csize) w_end_cred = 1'b1;
                end
                PH_DUR: begin
                    w_kind = KIND_ANIM;
                    if (w_done) begin
                        if (w_over) begin
                            n_err = ERR_FIELD_BIG;
                        end else begin
                            n_region = W'(0);
                            n_phase  = PH_CMAGIC;
                        end
                    end
                end
                PH_CMAGIC: begin
                    w_kind   = KIND_ANIM;
                    n_region = w_reg_inc;
                    if (w_done) begin
                        if (w_asm_or[31:0] != MAGIC_CIFF) n_err = ERR_IMG_MAGIC;
                        else n_phase = PH_CHS;
                    end
                end
                PH_CHS, PH_CCS, PH_CW, PH_CH: begin
                    w_kind   = KIND_ANIM;
                    n_region = w_reg_inc;
                    if (r_phase == PH_CH) begin
                        n_acc = w_acc_n;
                    end
                    if (w_done) begin
                        if (w_over) begin
                            n_err = ERR_FIELD_BIG;
                        end else if (r_phase == PH_CHS) begin
                            n_hsize = w_v;
                            n_phase = PH_CCS;
                        end else if (r_phase == PH_CCS) begin
                            n_csize = w_v;
                            n_phase = PH_CW;
                        end else if (r_phase == PH_CW) begin
                            n_w3    = {2'b00, w_v} + {1'b0, w_v, 1'b0};
                            n_acc   = '0;
                            n_phase = PH_CH;
                        end else if (w_acc_n != AccW'(r_csize)) begin
                            n_err = ERR_IMG_SIZE;
                        end else if (r_hsize <= W'(FIXED_IMG_HDR)) begin
                            n_err = ERR_CAPTION;
                        end else begin
                            n_phase = PH_CAPTION;
                        end
                    end
                end
                PH_CAPTION: begin
                    w_kind   = KIND_ANIM;
                    n_region = w_reg_inc;
                    if (i_beat.is_newline) begin
                        if (w_reg_inc >= r_hsize) n_err = ERR_TAGS;
                        else n_phase = PH_TAGS;
                    end else if (w_reg_inc >= r_hsize) begin
                        n_err = ERR_CAPTION;
                    end
                end
                PH_TAGS: begin
                    w_kind   = KIND_ANIM;
                    n_region = w_reg_inc;
                    if (w_reg_inc >= r_hsize) begin
                        if (!i_beat.is_zero) begin
                            n_err = ERR_TAGS;
                        end else begin
                            n_region = W'(0);
                            n_cnt    = 4'd0;
                            n_hold   = 16'd0;
                            if (r_csize == W'(0)) w_end_anim = 1'b1;
                            else n_phase = PH_PIX;
                        end
                    end
                end
                PH_PIX: begin
                    w_kind   = KIND_ANIM;
                    n_region = w_reg_inc;
                    if (r_cnt == 4'd0) begin
                        n_hold = {8'd0, i_beat.data};
                        n_cnt  = 4'd1;
                    end else if (r_cnt == 4'd1) begin
                        n_hold = {i_beat.data, r_hold[7:0]};
                        n_cnt  = 4'd2;
                    end else begin
                        w_pv   = 1'b1;
                        w_p1   = i_beat.data;
                        w_p2   = r_hold[15:8];
                        w_p3   = r_hold[7:0];
                        n_hold = 16'd0;
                        n_cnt  = 4'd0;
                    end
                    if (w_reg_inc >= r_csize) w_end_anim = 1'b1;
                end
                default: begin
                    n_err = ERR_TRAILING;
                end
            endcase

            if (w_end_cred) begin
                if ({1'b0, r_blen} != {1'b0, n_csize} + (W+1)'(CREDITS_FIXED)) begin
                    n_err = ERR_BLOCK_LEN;
                end else begin
                    n_blocks  = r_blocks + (W+1)'(1);
                    n_credits = 1'b1;
                    w_loop    = 1'b1;
                end
            end
            if (w_end_anim) begin
                if ({2'b00, r_blen} !=
                    {2'b00, r_hsize} + {2'b00, r_csize} + (W+2)'(DURATION_LEN)) begin
                    n_err = ERR_BLOCK_LEN;
                end else begin
                    n_blocks = r_blocks + (W+1)'(1);
                    n_frames = r_frames + (W+1)'(1);
                    w_loop   = 1'b1;
                end
            end
            // The block scan ends after frame_count frames or frame_count+1 blocks.
            if (w_loop) begin
                if (n_frames >= {1'b0, n_fcount} || n_blocks > {1'b0, n_fcount}) begin
                    if (!n_credits) n_err = ERR_NO_CRED;
                    else n_phase = PH_DONE;
                end else begin
                    n_phase = PH_BID;
                end
            end
            if (n_err == ERR_NONE && i_beat.eof) begin
                if (n_phase == PH_DONE) n_phase = PH_ENDED;
                else n_err = ERR_EARLY_END;
            end
        end

        n_out.error_code  = n_err;
        n_out.finished_ok = (n_err == ERR_NONE) && (n_phase == PH_ENDED);
        if (n_err != ERR_NONE) begin
            n_out.pixel_valid  = 1'b0;
            n_out.pixel_first  = 8'd0;
            n_out.pixel_second = 8'd0;
            n_out.pixel_third  = 8'd0;
            n_out.block_kind   = KIND_NONE;
        end else begin
            n_out.pixel_valid  = w_pv;
            n_out.pixel_first  = w_p1;
            n_out.pixel_second = w_p2;
            n_out.pixel_third  = w_p3;
            n_out.block_kind   = w_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HID;
            r_cnt       <= 4'd0;
            r_asm       <= 64'd0;
            r_region    <= '0;
            r_blen      <= '0;
            r_hsize     <= '0;
            r_csize     <= '0;
            r_w3        <= '0;
            r_acc       <= '0;
            r_fcount    <= '0;
            r_frames    <= '0;
            r_blocks    <= '0;
            r_credits   <= 1'b0;
            r_hold      <= 16'd0;
            r_err       <= ERR_NONE;
            r_id        <= KIND_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_asm       <= n_asm;
            r_region    <= n_region;
            r_blen      <= n_blen;
            r_hsize     <= n_hsize;
            r_csize     <= n_csize;
            r_w3        <= n_w3;
            r_acc       <= n_acc;
            r_fcount    <= n_fcount;
            r_frames    <= n_frames;
            r_blocks    <= n_blocks;
            r_credits   <= n_credits;
            r_hold      <= n_hold;
            r_err       <= n_err;
            r_id        <= n_id;
            r_out_valid <= w_take || (r_out_valid && !i_ready);
        end
    end

    `AICV_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err != ERR_NONE, r_err == $past(r_err), "error code changed after being set")
    `AICV_ASSERT_IMPL(a_pix_in_anim, i_clk, i_rst_n, r_out_valid && r_out.pixel_valid, r_out.block_kind == KIND_ANIM && r_out.error_code == ERR_NONE, "pixel outside an animation block")
    `AICV_ASSERT_IMPL(a_pix_count, i_clk, i_rst_n, r_phase == PH_PIX, r_cnt <= 4'd2, "pixel byte count out of range")
    `AICV_ASSERT_IMPL(a_ok_no_err, i_clk, i_rst_n, r_out_valid && r_out.finished_ok, r_phase == PH_ENDED && r_err == ERR_NONE, "finished without reaching the end state")

endmodule
`default_nettype wire

@@ src/animated_image_container_validator.sv @@
// ----------------------------------------------------------------------------
// animated_image_container_validator
// Byte-stream validator for a block-structured animated image container.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_ready     data_byte, end_of_file
//  result    out        o_out_valid / i_out_ready   error, finished, pixel, kind
//  config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  One byte per clock is sustained while the result output is accepted; each
//  byte's result passes through the beat queue and then the output register.
//  The whole per-byte parse step is combinational logic in the back end.
//  Reset clears control state at once, not stored data; no clearing pass.
//  A two-beat queue buffers input beats while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module animated_image_container_validator #(
    parameter int LEN_BITS = aicv_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_file,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_error_code,
    output logic             o_finished_ok,
    output logic             o_pixel_valid,
    output logic [7:0]       o_pixel_first,
    output logic [7:0]       o_pixel_second,
    output logic [7:0]       o_pixel_third,
    output logic [1:0]       o_block_kind,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import aicv_pkg::*;

    logic [15:0] r_year_min;
    logic [15:0] r_year_max;
    logic        w_q_valid;
    logic        w_q_ready;
    t_beat       w_beat;
    t_result     w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_min <= YEAR_MIN_RESET;
            r_year_max <= YEAR_MAX_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_YEAR_MIN) r_year_min <= i_cfg_data;
            else r_year_max <= i_cfg_data;
        end
    end

    aicv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_end_of_file(i_end_of_file),
        .o_valid      (w_q_valid),
        .i_ready      (w_q_ready),
        .o_beat       (w_beat)
    );

    aicv_back #(
        .LEN_BITS(LEN_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_year_min(r_year_min),
        .i_year_max(r_year_max),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_beat    (w_beat),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_result  (w_result)
    );

    assign o_error_code   = w_result.error_code;
    assign o_finished_ok  = w_result.finished_ok;
    assign o_pixel_valid  = w_result.pixel_valid;
    assign o_pixel_first  = w_result.pixel_first;
    assign o_pixel_second = w_result.pixel_second;
    assign o_pixel_third  = w_result.pixel_third;
    assign o_block_kind   = w_result.block_kind;

endmodule
`default_nettype wire
